// ===== rtl/sphk_pkg.sv =====
// Shared constants, codes and lane structs for the SPH smoothing kernel unit.
// No dependencies; every other file but sphk_if refers to this package by scoped names.
package sphk_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COEF_FRAC   = 32;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;
    localparam int LANES       = 4;
    localparam int A_W         = 68;
    localparam int M_W         = 64;
    localparam int SH_W        = 8;
    localparam int PROD_W      = 256;

    localparam int MUL_LAT     = 3;
    localparam int MUL_LIMBS   = 7;
    localparam int MUL_A_W     = 32 * MUL_LIMBS;
    localparam int MUL_ROW_W   = 32 * (MUL_LIMBS + 1);
    localparam int MUL_P_W     = MUL_ROW_W + 32;
    localparam int LANE_LAT    = 3 * MUL_LAT + 1 + DIV_STAGES;
    localparam int PIPE_LAT    = 3 + SQRT_STAGES + 1 + LANE_LAT + 1;

    localparam logic [SH_W-1:0] SH_POLY6 = SH_W'(COEF_FRAC + 5 * FRAC_BITS);
    localparam logic [SH_W-1:0] SH_LAPL  = SH_W'(COEF_FRAC + 3 * FRAC_BITS);
    localparam logic [SH_W-1:0] SH_GRAD  = SH_W'(COEF_FRAC + 4 * FRAC_BITS);
    localparam logic [SH_W-1:0] SH_SPIKY = SH_W'(COEF_FRAC + FRAC_BITS);
    localparam logic [SH_W-1:0] SH_VISC  = SH_W'(COEF_FRAC);

    localparam logic [2:0] ACT_POLY6      = 3'd0;
    localparam logic [2:0] ACT_POLY6_GRAD = 3'd1;
    localparam logic [2:0] ACT_POLY6_LAPL = 3'd2;
    localparam logic [2:0] ACT_SPIKY_GRAD = 3'd3;
    localparam logic [2:0] ACT_VISC_LAPL  = 3'd4;

    localparam logic [1:0] REG_SMOOTHING_LENGTH = 2'd0;
    localparam logic [1:0] REG_POLY6_COEF       = 2'd1;
    localparam logic [1:0] REG_POLY6_DERIV_COEF = 2'd2;
    localparam logic [1:0] REG_SPIKY_COEF       = 2'd3;

    typedef struct packed {
        logic [A_W-1:0]  a;
        logic [M_W-1:0]  m1;
        logic [M_W-1:0]  m2;
        logic [M_W-1:0]  m3;
        logic [SH_W-1:0] sh;
        logic            spiky;
        logic            neg;
        logic [31:0]     len;
    } t_lane_op;

    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
        logic        sat;
    } t_lane_res;

endpackage

// ===== rtl/sphk_if.sv =====
// Valid/ready channel interfaces: input items, result items, register writes.
// Depends on nothing; widths follow the fixed item and register formats.
interface sphk_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [30:0]        distance;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    modport source (output valid, action, distance, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, action, distance, vec_x, vec_y, vec_z, output ready);
endinterface

interface sphk_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic               outside;
    logic               saturated;
    modport source (output valid, value, grad_x, grad_y, grad_z, outside, saturated,
                    input ready);
    modport sink   (input valid, value, grad_x, grad_y, grad_z, outside, saturated,
                    output ready);
endinterface

interface sphk_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [62:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/sph_smoothing_kernel_unit.sv =====
// Top level: registers, front end (squares, root), four kernel lanes, merge.
// Depends on sphk_pkg, sphk_if, sphk_sqrt and sphk_lane.
//
//   channel   dir   beat carries
//   i_cfg     in    index, data          register write
//   i_in      in    action, distance, vec_x, vec_y, vec_z
//   o_out     out   value, grad_x, grad_y, grad_z, outside, saturated
//
// One item per cycle while the output is taken; items pass the 32-stage root, the three
// 3-stage multiplies and the 32-stage divide in each lane. Reset clears the valid
// line and loads the register defaults. A stalled output holds the whole pipeline;
// i_in.ready stays high while the output stage is empty or being taken. Register
// writes are always taken.
module sph_smoothing_kernel_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sphk_cfg_if.sink    i_cfg,
    sphk_in_if.sink     i_in,
    sphk_out_if.source  o_out
);

    typedef struct packed {
        logic [2:0]  action;
        logic [30:0] d;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } t_p0;

    typedef struct packed {
        logic [2:0]       action;
        logic [30:0]      d;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [2:0][63:0] sq;
        logic [61:0]      dd;
        logic [61:0]      h2;
    } t_p1;

    typedef struct packed {
        logic [2:0]       action;
        logic [30:0]      d;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [61:0]      s_d;
        logic [61:0]      s_v;
        logic [67:0]      lmag;
        logic             lneg;
        logic             outside;
    } t_side;

    logic [30:0]                    r_h;
    logic [62:0]                    r_c6;
    logic [62:0]                    r_cd;
    logic [62:0]                    r_cs;
    logic [sphk_pkg::PIPE_LAT-1:0]  r_vld;
    logic                           w_en;
    t_p0                            r_p0;
    t_p1                            r_p1;
    t_p1                            n_p1;
    t_side                          r_p2;
    t_side                          n_p2;
    logic [63:0]                    r_sum;
    logic [63:0]                    n_sum;
    t_side                          r_sq_side [sphk_pkg::SQRT_STAGES];
    logic [31:0]                    w_len;
    sphk_pkg::t_lane_op             r_op [sphk_pkg::LANES];
    sphk_pkg::t_lane_op             n_op [sphk_pkg::LANES];
    sphk_pkg::t_lane_res            w_res [sphk_pkg::LANES];
    logic [sphk_pkg::LANE_LAT-1:0]  r_oside;
    logic                           r_p3_out;
    logic signed [31:0]             r_value;
    logic signed [31:0]             r_gx;
    logic signed [31:0]             r_gy;
    logic signed [31:0]             r_gz;
    logic                           r_outside;
    logic                           r_sat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h  <= 31'd65536;
            r_c6 <= '0;
            r_cd <= '0;
            r_cs <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                sphk_pkg::REG_SMOOTHING_LENGTH: r_h  <= i_cfg.data[30:0];
                sphk_pkg::REG_POLY6_COEF:       r_c6 <= i_cfg.data;
                sphk_pkg::REG_POLY6_DERIV_COEF: r_cd <= i_cfg.data;
                sphk_pkg::REG_SPIKY_COEF:       r_cs <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign w_en        = !r_vld[sphk_pkg::PIPE_LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[sphk_pkg::PIPE_LAT-2:0], i_in.valid};
        end
    end

    always_comb begin
        logic [2:0][31:0] v;
        v              = {r_p0.vz, r_p0.vy, r_p0.vx};
        n_p1.action    = r_p0.action;
        n_p1.d         = r_p0.d;
        for (int i = 0; i < 3; i++) begin
            n_p1.neg[i] = v[i][31];
            n_p1.mag[i] = v[i][31] ? (32'd0 - v[i]) : v[i];
            n_p1.sq[i]  = {32'd0, n_p1.mag[i]} * {32'd0, n_p1.mag[i]};
        end
        n_p1.dd = {31'd0, r_p0.d} * {31'd0, r_p0.d};
        n_p1.h2 = {31'd0, r_h} * {31'd0, r_h};
    end

    always_comb begin
        logic [67:0] a42;
        logic [67:0] b18;
        n_sum        = r_p1.sq[0] + r_p1.sq[1] + r_p1.sq[2];
        a42          = {6'd0, r_p1.dd} * 68'd42;
        b18          = {6'd0, r_p1.h2} * 68'd18;
        n_p2.action  = r_p1.action;
        n_p2.d       = r_p1.d;
        n_p2.mag     = r_p1.mag;
        n_p2.neg     = r_p1.neg;
        n_p2.s_d     = r_p1.h2 - r_p1.dd;
        n_p2.s_v     = r_p1.h2 - n_sum[61:0];
        n_p2.lneg    = (a42 < b18);
        n_p2.lmag    = n_p2.lneg ? (b18 - a42) : (a42 - b18);
        unique case (r_p1.action)
            sphk_pkg::ACT_POLY6, sphk_pkg::ACT_POLY6_LAPL, sphk_pkg::ACT_VISC_LAPL:
                n_p2.outside = (r_p1.d > r_h);
            sphk_pkg::ACT_POLY6_GRAD, sphk_pkg::ACT_SPIKY_GRAD:
                n_p2.outside = (n_sum > {2'd0, r_p1.h2});
            default:
                n_p2.outside = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0  <= '{action: i_in.action, d: i_in.distance, vx: i_in.vec_x,
                       vy: i_in.vec_y, vz: i_in.vec_z};
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_sum <= n_sum;
            r_sq_side[0] <= r_p2;
            for (int k = 1; k < sphk_pkg::SQRT_STAGES; k++) begin
                r_sq_side[k] <= r_sq_side[k-1];
            end
        end
    end

    sphk_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_val  (r_sum),
        .o_root (w_len)
    );

    always_comb begin
        t_side       s;
        logic [31:0] e;
        s = r_sq_side[sphk_pkg::SQRT_STAGES-1];
        e = {1'b0, r_h} - w_len;
        for (int i = 0; i < sphk_pkg::LANES; i++) begin
            n_op[i] = '0;
        end
        if (!s.outside) begin
            unique case (s.action)
                sphk_pkg::ACT_POLY6: begin
                    n_op[0].a  = {6'd0, s.s_d};
                    n_op[0].m1 = {2'd0, s.s_d};
                    n_op[0].m2 = {2'd0, s.s_d};
                    n_op[0].m3 = {1'b0, r_c6};
                    n_op[0].sh = sphk_pkg::SH_POLY6;
                end
                sphk_pkg::ACT_POLY6_LAPL: begin
                    n_op[0].a   = s.lmag;
                    n_op[0].m1  = {2'd0, s.s_d};
                    n_op[0].m2  = {1'b0, r_cd};
                    n_op[0].m3  = 64'd1;
                    n_op[0].sh  = sphk_pkg::SH_LAPL;
                    n_op[0].neg = s.lneg;
                end
                sphk_pkg::ACT_VISC_LAPL: begin
                    n_op[0].a  = {37'd0, r_h - s.d};
                    n_op[0].m1 = {1'b0, r_cs};
                    n_op[0].m2 = 64'd1;
                    n_op[0].m3 = 64'd1;
                    n_op[0].sh = sphk_pkg::SH_VISC;
                end
                sphk_pkg::ACT_POLY6_GRAD: begin
                    for (int i = 0; i < 3; i++) begin
                        n_op[i+1].a   = {36'd0, s.mag[i]};
                        n_op[i+1].m1  = {2'd0, s.s_v};
                        n_op[i+1].m2  = {2'd0, s.s_v};
                        n_op[i+1].m3  = {1'b0, r_cd};
                        n_op[i+1].sh  = sphk_pkg::SH_GRAD;
                        n_op[i+1].neg = s.neg[i];
                    end
                end
                sphk_pkg::ACT_SPIKY_GRAD: begin
                    if (w_len != 32'd0) begin
                        for (int i = 0; i < 3; i++) begin
                            n_op[i+1].a     = {36'd0, s.mag[i]};
                            n_op[i+1].m1    = {1'b0, r_cs};
                            n_op[i+1].m2    = {32'd0, e};
                            n_op[i+1].m3    = {32'd0, e};
                            n_op[i+1].sh    = sphk_pkg::SH_SPIKY;
                            n_op[i+1].neg   = s.neg[i];
                            n_op[i+1].spiky = 1'b1;
                            n_op[i+1].len   = w_len;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < sphk_pkg::LANES; i++) begin
                r_op[i] <= n_op[i];
            end
            r_p3_out <= r_sq_side[sphk_pkg::SQRT_STAGES-1].outside;
            r_oside  <= {r_oside[sphk_pkg::LANE_LAT-2:0], r_p3_out};
        end
    end

    for (genvar g = 0; g < sphk_pkg::LANES; g++) begin : g_lane
        sphk_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_op  (r_op[g]),
            .o_res (w_res[g])
        );
    end

    function automatic logic [31:0] apply_sign(input sphk_pkg::t_lane_res r);
        return r.neg ? (32'd0 - r.mag) : r.mag;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value   <= apply_sign(w_res[0]);
            r_gx      <= apply_sign(w_res[1]);
            r_gy      <= apply_sign(w_res[2]);
            r_gz      <= apply_sign(w_res[3]);
            r_outside <= r_oside[sphk_pkg::LANE_LAT-1];
            r_sat     <= w_res[0].sat | w_res[1].sat | w_res[2].sat | w_res[3].sat;
        end
    end

    assign o_out.valid     = r_vld[sphk_pkg::PIPE_LAT-1];
    assign o_out.value     = r_value;
    assign o_out.grad_x    = r_gx;
    assign o_out.grad_y    = r_gy;
    assign o_out.grad_z    = r_gz;
    assign o_out.outside   = r_outside;
    assign o_out.saturated = r_sat;

endmodule

// ===== rtl/sphk_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, 64-bit radicand.
// Depends on sphk_pkg for the stage count.
module sphk_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_val,
    output logic [31:0] o_root
);

    logic [63:0] r_n [sphk_pkg::SQRT_STAGES];
    logic [63:0] r_r [sphk_pkg::SQRT_STAGES];

    for (genvar k = 0; k < sphk_pkg::SQRT_STAGES; k++) begin : g_st
        logic [63:0] src_n;
        logic [63:0] src_r;
        logic [63:0] bitv;
        logic [63:0] trial;
        logic        ge;
        logic [63:0] n_n;
        logic [63:0] n_r;

        if (k == 0) begin : g_first
            assign src_n = i_val;
            assign src_r = 64'd0;
        end else begin : g_next
            assign src_n = r_n[k-1];
            assign src_r = r_r[k-1];
        end

        assign bitv  = 64'd1 << (62 - 2 * k);
        assign trial = src_r + bitv;
        assign ge    = (src_n >= trial);
        assign n_n   = ge ? (src_n - trial) : src_n;
        assign n_r   = ge ? ((src_r >> 1) + bitv) : (src_r >> 1);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k] <= n_n;
                r_r[k] <= n_r;
            end
        end
    end

    assign o_root = r_r[sphk_pkg::SQRT_STAGES-1][31:0];

endmodule

// ===== rtl/sphk_lane.sv =====
// Pipelined wide multiplier and one kernel lane: product chain, scaling shift,
// pipelined divide and clip. Depends on sphk_pkg for structs and stage counts.
module sphk_mul (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sphk_pkg::MUL_A_W-1:0]  i_a,
    input  logic [63:0]                   i_b,
    output logic [sphk_pkg::MUL_P_W-1:0]  o_p
);

    logic [63:0]                     r_pp [sphk_pkg::MUL_LIMBS][2];
    logic [sphk_pkg::MUL_ROW_W-1:0]  r_row [2];
    logic [sphk_pkg::MUL_ROW_W-1:0]  n_row [2];
    logic [sphk_pkg::MUL_P_W-1:0]    r_p;

    always_comb begin
        logic [sphk_pkg::MUL_ROW_W-1:0] even;
        logic [sphk_pkg::MUL_ROW_W-1:0] odd;
        for (int j = 0; j < 2; j++) begin
            even = '0;
            odd  = '0;
            for (int i = 0; i < sphk_pkg::MUL_LIMBS; i++) begin
                if ((i % 2) == 0) begin
                    even[32*i +: 64] = r_pp[i][j];
                end else begin
                    odd[32*i +: 64] = r_pp[i][j];
                end
            end
            n_row[j] = even + odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < sphk_pkg::MUL_LIMBS; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r_pp[i][j] <= {32'd0, i_a[32*i +: 32]} * {32'd0, i_b[32*j +: 32]};
                end
            end
            r_row[0] <= n_row[0];
            r_row[1] <= n_row[1];
            r_p      <= {32'd0, r_row[0]} + {r_row[1], 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

module sphk_lane (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  sphk_pkg::t_lane_op   i_op,
    output sphk_pkg::t_lane_res  o_res
);

    typedef struct packed {
        logic [sphk_pkg::M_W-1:0]  m2;
        logic [sphk_pkg::M_W-1:0]  m3;
        logic [sphk_pkg::SH_W-1:0] sh;
        logic                      spiky;
        logic                      neg;
        logic [31:0]               len;
    } t_ctl;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] x;
        logic [31:0] len;
        logic [31:0] mag;
        logic        neg;
        logic        sat;
        logic        done;
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div        r;
        logic [32:0] t;
        logic [32:0] diff;
        logic        ge;
        r    = s;
        t    = {s.rem, s.x[31]};
        diff = t - {1'b0, s.len};
        ge   = (t >= {1'b0, s.len});
        if (!s.done) begin
            r.rem = ge ? diff[31:0] : t[31:0];
            r.x   = {s.x[30:0], ge};
        end
        return r;
    endfunction

    logic [sphk_pkg::MUL_P_W-1:0]  w_p1;
    logic [sphk_pkg::MUL_P_W-1:0]  w_p2;
    logic [sphk_pkg::MUL_P_W-1:0]  w_p3;
    t_ctl                          r_ctl [3*sphk_pkg::MUL_LAT];
    t_ctl                          w_c;
    t_div                          r_shs;
    t_div                          n_shs;
    t_div                          r_d [sphk_pkg::DIV_STAGES];
    logic [sphk_pkg::PROD_W-1:0]   w_y;
    logic [31:0]                   w_lim;

    sphk_mul u_mul1 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   ((sphk_pkg::MUL_A_W)'(i_op.a)),
        .i_b   (i_op.m1),
        .o_p   (w_p1)
    );

    sphk_mul u_mul2 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   ((sphk_pkg::MUL_A_W)'(w_p1[sphk_pkg::A_W+sphk_pkg::M_W-1:0])),
        .i_b   (r_ctl[sphk_pkg::MUL_LAT-1].m2),
        .o_p   (w_p2)
    );

    sphk_mul u_mul3 (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   ((sphk_pkg::MUL_A_W)'(w_p2[sphk_pkg::A_W+2*sphk_pkg::M_W-1:0])),
        .i_b   (r_ctl[2*sphk_pkg::MUL_LAT-1].m3),
        .o_p   (w_p3)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= '{m2: i_op.m2, m3: i_op.m3, sh: i_op.sh, spiky: i_op.spiky,
                          neg: i_op.neg, len: i_op.len};
            for (int k = 1; k < 3 * sphk_pkg::MUL_LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_shs <= n_shs;
        end
    end

    assign w_c   = r_ctl[3*sphk_pkg::MUL_LAT-1];
    assign w_y   = w_p3[sphk_pkg::PROD_W-1:0] >> w_c.sh;
    assign w_lim = w_c.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    always_comb begin
        n_shs      = '0;
        n_shs.len  = w_c.len;
        n_shs.neg  = w_c.neg;
        n_shs.done = 1'b1;
        if (w_c.spiky) begin
            if ((|w_y[255:64]) || (w_y[63:32] >= w_c.len)) begin
                n_shs.mag = w_lim;
                n_shs.sat = 1'b1;
            end else begin
                n_shs.done = 1'b0;
                n_shs.rem  = w_y[63:32];
                n_shs.x    = w_y[31:0];
            end
        end else if ((|w_y[255:32]) || (w_y[31:0] > w_lim)) begin
            n_shs.mag = w_lim;
            n_shs.sat = 1'b1;
        end else begin
            n_shs.mag = w_y[31:0];
        end
    end

    for (genvar k = 0; k < sphk_pkg::DIV_STAGES; k++) begin : g_div
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= div_step(r_shs);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= div_step(r_d[k-1]);
                end
            end
        end
    end

    always_comb begin
        t_div        f;
        logic [31:0] lim;
        f         = r_d[sphk_pkg::DIV_STAGES-1];
        lim       = f.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        o_res.neg = f.neg;
        if (f.done) begin
            o_res.mag = f.mag;
            o_res.sat = f.sat;
        end else if (f.x > lim) begin
            o_res.mag = lim;
            o_res.sat = 1'b1;
        end else begin
            o_res.mag = f.x;
            o_res.sat = 1'b0;
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for sph_smoothing_kernel_unit: random and directed kernel beats
// checked against an in-bench fixed-point predictor over several register settings.
// Depends on sphk_pkg and the channel interfaces in sphk_if.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN = 100;

    typedef struct {
        bit [2:0]         action;
        bit [30:0]        distance;
        bit signed [31:0] vx;
        bit signed [31:0] vy;
        bit signed [31:0] vz;
    } t_kernel_req;

    typedef struct {
        bit [31:0] value;
        bit [31:0] gx;
        bit [31:0] gy;
        bit [31:0] gz;
        bit        outside;
        bit        sat;
    } t_kernel_res;

    logic clk;
    logic i_rst_n;
    sphk_cfg_if cfg_if ();
    sphk_in_if  in_if ();
    sphk_out_if out_if ();

    sph_smoothing_kernel_unit dut (
        .i_clk  (clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if.sink),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    bit [30:0] h_len;
    bit [62:0] c_poly6;
    bit [62:0] c_deriv;
    bit [62:0] c_spiky;

    t_kernel_req pending_reqs[$];
    t_kernel_res expected_res[$];
    int          n_errors;
    int          n_cycles;
    int          cfg_beats;
    bit          no_idle;
    bit          in_fire;
    int          send_gap;
    int          recv_stall;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [31:0] clip32(bit [255:0] a, bit n, inout bit sat);
        bit [255:0] lim;
        lim = n ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (a > lim) begin
            a = lim;
            sat = 1'b1;
        end
        return n ? (32'h0 - a[31:0]) : a[31:0];
    endfunction

    function automatic bit [63:0] root64(bit [63:0] n);
        bit [63:0] r;
        bit [63:0] t;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic t_kernel_res kernel_eval(t_kernel_req q);
        t_kernel_res res;
        bit [255:0]  acc;
        bit [255:0]  b;
        bit [63:0]   h;
        bit [63:0]   h2;
        bit [63:0]   d;
        bit [63:0]   s;
        bit [63:0]   sum;
        bit [63:0]   len;
        bit [63:0]   e;
        bit [63:0]   mag[3];
        bit          neg[3];
        bit [31:0]   comp[3];
        bit [31:0]   g[3];
        bit          lneg;
        bit          sat;
        res = '{default: 0};
        sat = 1'b0;
        h = h_len;
        h2 = h * h;
        d = q.distance;
        comp[0] = q.vx;
        comp[1] = q.vy;
        comp[2] = q.vz;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = comp[i][31];
            mag[i] = neg[i] ? (64'h1_0000_0000 - comp[i]) : comp[i];
            sum += mag[i] * mag[i];
            g[i] = 0;
        end
        case (q.action)
            sphk_pkg::ACT_POLY6, sphk_pkg::ACT_POLY6_LAPL, sphk_pkg::ACT_VISC_LAPL: begin
                if (d > h) begin
                    res.outside = 1'b1;
                    return res;
                end
                s = h2 - d * d;
                if (q.action == sphk_pkg::ACT_POLY6) begin
                    acc = 256'(s) * s * s * c_poly6;
                    res.value = clip32(acc >> (sphk_pkg::COEF_FRAC + 5 * sphk_pkg::FRAC_BITS),
                                       1'b0, sat);
                end else if (q.action == sphk_pkg::ACT_POLY6_LAPL) begin
                    acc = 256'(d * d) * 42;
                    b = 256'(h2) * 18;
                    lneg = acc < b;
                    acc = lneg ? b - acc : acc - b;
                    acc = acc * s * c_deriv;
                    res.value = clip32(acc >> (sphk_pkg::COEF_FRAC + 3 * sphk_pkg::FRAC_BITS),
                                       lneg, sat);
                end else begin
                    acc = 256'(h - d) * c_spiky;
                    res.value = clip32(acc >> sphk_pkg::COEF_FRAC, 1'b0, sat);
                end
            end
            sphk_pkg::ACT_POLY6_GRAD, sphk_pkg::ACT_SPIKY_GRAD: begin
                if (sum > h2) begin
                    res.outside = 1'b1;
                    return res;
                end
                if (q.action == sphk_pkg::ACT_POLY6_GRAD) begin
                    s = h2 - sum;
                    for (int i = 0; i < 3; i++) begin
                        acc = 256'(mag[i]) * s * s * c_deriv;
                        g[i] = clip32(acc >> (sphk_pkg::COEF_FRAC + 4 * sphk_pkg::FRAC_BITS),
                                      neg[i], sat);
                    end
                end else begin
                    len = root64(sum);
                    if (len != 0) begin
                        e = h - len;
                        for (int i = 0; i < 3; i++) begin
                            acc = 256'(mag[i]) * c_spiky * e * e;
                            acc = (acc >> (sphk_pkg::COEF_FRAC + sphk_pkg::FRAC_BITS)) / len;
                            g[i] = clip32(acc, neg[i], sat);
                        end
                    end
                end
                res.gx = g[0];
                res.gy = g[1];
                res.gz = g[2];
            end
            default: return res;
        endcase
        res.sat = sat;
        return res;
    endfunction

    function automatic bit signed [31:0] rand_comp(bit [63:0] span);
        return 32'($signed(65'($urandom_range(0, 32'(2 * span)))) - $signed(65'(span)));
    endfunction

    function automatic t_kernel_req rand_req();
        t_kernel_req q;
        int          r;
        bit [63:0]   half;
        if ($urandom_range(0, 99) < 95) q.action = 3'($urandom_range(0, 4));
        else q.action = 3'($urandom_range(sphk_pkg::ACT_VISC_LAPL + 1, 7));
        r = $urandom_range(0, 99);
        if (r < 70) q.distance = 31'($urandom_range(0, h_len));
        else if (r < 80) q.distance = h_len;
        else q.distance = 31'($urandom);
        half = h_len / 2;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            q.vx = rand_comp(half);
            q.vy = rand_comp(half);
            q.vz = rand_comp(half);
        end else if (r < 78) begin
            q.vx = $urandom_range(0, 1) ? 32'(h_len) : -32'(h_len);
            q.vy = 0;
            q.vz = 0;
        end else if (r < 80) begin
            q.vx = 0;
            q.vy = 0;
            q.vz = 0;
        end else begin
            q.vx = $urandom;
            q.vy = $urandom;
            q.vz = $urandom;
        end
        return q;
    endfunction

    function automatic t_kernel_req mk(bit [2:0] a, bit [30:0] d, bit [31:0] x, bit [31:0] y,
                                       bit [31:0] z);
        t_kernel_req q;
        q.action = a;
        q.distance = d;
        q.vx = x;
        q.vy = y;
        q.vz = z;
        return q;
    endfunction

    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
        if (cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                sphk_pkg::REG_SMOOTHING_LENGTH: h_len = cfg_if.data[30:0];
                sphk_pkg::REG_POLY6_COEF:       c_poly6 = cfg_if.data;
                sphk_pkg::REG_POLY6_DERIV_COEF: c_deriv = cfg_if.data;
                default:                        c_spiky = cfg_if.data;
            endcase
            cfg_beats <= cfg_beats + 1;
        end
    end

    always @(posedge clk) begin
        in_fire <= in_if.valid && in_if.ready;
        if (in_if.valid && in_if.ready)
            expected_res.push_back(kernel_eval(mk(in_if.action, in_if.distance, in_if.vec_x,
                                                  in_if.vec_y, in_if.vec_z)));
    end

    always @(posedge clk) begin
        t_kernel_res exp_r;
        if (out_if.valid && out_if.ready) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result beat value=%h", $realtime, out_if.value);
                n_errors++;
            end else begin
                exp_r = expected_res.pop_front();
                if (out_if.value !== exp_r.value || out_if.grad_x !== exp_r.gx ||
                    out_if.grad_y !== exp_r.gy || out_if.grad_z !== exp_r.gz ||
                    out_if.outside !== exp_r.outside || out_if.saturated !== exp_r.sat) begin
                    $display({"%0t: expected v=%h g=%h,%h,%h o=%b s=%b",
                              " got v=%h g=%h,%h,%h o=%b s=%b"},
                             $realtime, exp_r.value, exp_r.gx, exp_r.gy, exp_r.gz,
                             exp_r.outside, exp_r.sat, out_if.value, out_if.grad_x,
                             out_if.grad_y, out_if.grad_z, out_if.outside, out_if.saturated);
                    n_errors++;
                end
            end
        end
    end

    always @(negedge clk) begin
        t_kernel_req q;
        if (i_rst_n && (!in_if.valid || in_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                q = pending_reqs.pop_front();
                in_if.action <= q.action;
                in_if.distance <= q.distance;
                in_if.vec_x <= q.vx;
                in_if.vec_y <= q.vy;
                in_if.vec_z <= q.vz;
                in_if.valid <= 1'b1;
                send_gap = no_idle ? 0 : gap_len();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (i_rst_n) begin
            if (recv_stall > 0) begin
                recv_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                recv_stall = no_idle ? 0 : gap_len();
            end
        end
    end

    task automatic write_reg(bit [1:0] idx, bit [62:0] val);
        int seen;
        seen = cfg_beats;
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data <= val;
        cfg_if.valid <= 1'b1;
        while (cfg_beats == seen) @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(bit [30:0] h, bit [62:0] c6, bit [62:0] cd, bit [62:0] cs);
        write_reg(sphk_pkg::REG_SMOOTHING_LENGTH, 63'(h));
        write_reg(sphk_pkg::REG_POLY6_COEF, c6);
        write_reg(sphk_pkg::REG_POLY6_DERIV_COEF, cd);
        write_reg(sphk_pkg::REG_SPIKY_COEF, cs);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (pending_reqs.size() != 0 || in_if.valid || expected_res.size() != 0)
            @(negedge clk);
        while (waited < DRAIN) begin
            @(negedge clk);
            waited++;
        end
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) pending_reqs.push_back(rand_req());
        drain();
    endtask

    initial begin
        bit [30:0] h;
        h_len = 31'd65536;
        c_poly6 = 0;
        c_deriv = 0;
        c_spiky = 0;
        n_errors = 0;
        n_cycles = 0;
        cfg_beats = 0;
        in_fire = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        in_if.valid = 1'b0;
        in_if.action = '0;
        in_if.distance = '0;
        in_if.vec_x = '0;
        in_if.vec_y = '0;
        in_if.vec_z = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        i_rst_n = 1'b1;

        run_random(60);

        set_regs(31'd65536, 63'd6729331710, 63'd40370000000, 63'd61510000000);
        h = 31'd65536;
        for (int a = sphk_pkg::ACT_POLY6; a <= sphk_pkg::ACT_VISC_LAPL; a++) begin
            pending_reqs.push_back(mk(3'(a), 0, 0, 0, 0));
            pending_reqs.push_back(mk(3'(a), h, 32'(h), 0, 0));
            pending_reqs.push_back(mk(3'(a), h + 1, 0, 0, -32'(h) - 1));
            pending_reqs.push_back(mk(3'(a), 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                      32'h8000_0000));
        end
        pending_reqs.push_back(mk(sphk_pkg::ACT_SPIKY_GRAD, 0, 1, -1, 0));
        pending_reqs.push_back(mk(sphk_pkg::ACT_POLY6_GRAD, 100, -32'sd30000, 32'sd20000,
                                  -32'sd100));
        pending_reqs.push_back(mk(sphk_pkg::ACT_POLY6_LAPL, 31'd30000, 0, 0, 0));
        pending_reqs.push_back(mk(3'(sphk_pkg::ACT_VISC_LAPL + 1), 5, 32'hFFFF_FFFF, 7, 9));
        pending_reqs.push_back(mk(3'h7, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
        drain();
        run_random(220);

        no_idle = 1'b1;
        set_regs(31'h7FFF_FFFF, 63'($urandom), {31'($urandom), 32'($urandom)}, 63'($urandom));
        run_random(180);
        no_idle = 1'b0;

        set_regs(31'd0, 63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF,
                 63'h7FFF_FFFF_FFFF_FFFF);
        run_random(150);

        set_regs(31'($urandom_range(1 << 16, 1 << 24)), {31'($urandom), 32'($urandom)},
                 {31'($urandom), 32'($urandom)}, {31'($urandom), 32'($urandom)});
        run_random(250);

        set_regs(31'd4096, 63'($urandom) << 20, 63'($urandom) << 24, 63'($urandom) << 12);
        run_random(200);

        set_regs(31'($urandom), 63'($urandom_range(0, 1000)), 63'($urandom), 63'(1));
        run_random(150);

        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
